// ===== rtl/lpcd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared types and codes for the length-prefixed chunk deframer.
// ----------------------------------------------------------------------------
package lpcd_pkg;

    localparam int CHUNK_LIMIT_MAX = 4096;
    localparam int LIMIT_W         = 13;
    localparam int TOTAL_W         = 48;
    localparam int LEN_W           = 32;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_CHUNK = 3'd0;
    localparam logic [LIMIT_W-1:0]    MAX_CHUNK_RESET = 13'd4096;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [2:0] ST_DATA      = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_BAD_REPLY = 3'd2;
    localparam logic [2:0] ST_LOST      = 3'd3;
    localparam logic [2:0] ST_PEER_ERR  = 3'd4;
    localparam logic [2:0] ST_TOO_BIG   = 3'd5;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_REPLY   = 2'd1;
    localparam logic [1:0] PH_LENGTH  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [7:0]       REPLY_BYTE0    = 8'h4F;
    localparam logic [7:0]       REPLY_BYTE1    = 8'h4B;
    localparam logic [LEN_W-1:0] PEER_ERROR_LEN = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         payload_byte;
        logic               chunk_last;
        logic [TOTAL_W-1:0] total_bytes;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

// ===== rtl/lpcd_regs.sv =====
// ----------------------------------------------------------------------------
// lpcd_regs
// APB register file holding the chunk length limit; presents the clamped limit.
// ----------------------------------------------------------------------------
module lpcd_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpcd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lpcd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lpcd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [lpcd_pkg::LIMIT_W-1:0]      o_limit
);

    logic [lpcd_pkg::LIMIT_W-1:0] r_max_chunk;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == lpcd_pkg::ADDR_MAX_CHUNK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chunk <= lpcd_pkg::MAX_CHUNK_RESET;
        end else if (wr_en) begin
            r_max_chunk <= pwdata[lpcd_pkg::LIMIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == lpcd_pkg::ADDR_MAX_CHUNK) begin
            prdata = {{(lpcd_pkg::APB_DATA_W-lpcd_pkg::LIMIT_W){1'b0}}, r_max_chunk};
        end
    end

    // clamp to the hardware limit
    assign o_limit = (r_max_chunk > lpcd_pkg::LIMIT_W'(lpcd_pkg::CHUNK_LIMIT_MAX))
                   ? lpcd_pkg::LIMIT_W'(lpcd_pkg::CHUNK_LIMIT_MAX) : r_max_chunk;

endmodule

// ===== rtl/lpcd_parser.sv =====
// ----------------------------------------------------------------------------
// lpcd_parser
// Transfer state and per-byte parse step: reply check, length field, payload.
// ----------------------------------------------------------------------------
module lpcd_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  lpcd_pkg::t_in_item            i_item,
    input  logic [lpcd_pkg::LIMIT_W-1:0]  i_limit,
    output lpcd_pkg::t_result             o_result
);

    logic [1:0]                   r_phase,     n_phase;
    logic [1:0]                   r_idx,       n_idx;
    logic                         r_mismatch,  n_mismatch;
    logic [lpcd_pkg::LEN_W-9:0]   r_len,       n_len;
    logic [lpcd_pkg::LIMIT_W-1:0] r_remaining, n_remaining;
    logic [lpcd_pkg::TOTAL_W-1:0] r_total,     n_total;

    logic [lpcd_pkg::LEN_W-1:0]   len_shift;
    logic [7:0]                   want;
    logic                         last;

    assign len_shift = {r_len, i_item.rx_byte};
    assign want      = (r_idx == 2'd0) ? lpcd_pkg::REPLY_BYTE0 : lpcd_pkg::REPLY_BYTE1;
    assign last      = (r_remaining <= lpcd_pkg::LIMIT_W'(1));

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_mismatch  = r_mismatch;
        n_len       = r_len;
        n_remaining = r_remaining;
        n_total     = r_total;
        o_result    = '0;

        if (i_item.operation == lpcd_pkg::OP_START) begin
            n_phase     = lpcd_pkg::PH_REPLY;
            n_idx       = '0;
            n_mismatch  = 1'b0;
            n_len       = '0;
            n_remaining = '0;
            n_total     = '0;
        end else if (r_phase != lpcd_pkg::PH_IDLE) begin
            if (i_item.operation == lpcd_pkg::OP_CLOSE) begin
                o_result.valid       = 1'b1;
                o_result.item.status = (r_phase == lpcd_pkg::PH_REPLY)
                                     ? lpcd_pkg::ST_BAD_REPLY : lpcd_pkg::ST_LOST;
                n_phase              = lpcd_pkg::PH_IDLE;
            end else if (i_item.operation == lpcd_pkg::OP_BYTE) begin
                unique case (r_phase)
                    lpcd_pkg::PH_REPLY: begin
                        n_mismatch = r_mismatch | (i_item.rx_byte != want);
                        if (r_idx == 2'd0) begin
                            n_idx = 2'd1;
                        end else begin
                            n_idx = '0;
                            if (n_mismatch) begin
                                n_phase              = lpcd_pkg::PH_IDLE;
                                o_result.valid       = 1'b1;
                                o_result.item.status = lpcd_pkg::ST_BAD_REPLY;
                            end else begin
                                n_phase = lpcd_pkg::PH_LENGTH;
                                n_len   = '0;
                            end
                        end
                    end
                    lpcd_pkg::PH_LENGTH: begin
                        n_len = len_shift[lpcd_pkg::LEN_W-9:0];
                        if (r_idx != 2'd3) begin
                            n_idx = r_idx + 2'd1;
                        end else begin
                            n_idx = '0;
                            if (len_shift == lpcd_pkg::PEER_ERROR_LEN) begin
                                n_phase              = lpcd_pkg::PH_IDLE;
                                o_result.valid       = 1'b1;
                                o_result.item.status = lpcd_pkg::ST_PEER_ERR;
                            end else if (len_shift == '0) begin
                                n_phase              = lpcd_pkg::PH_IDLE;
                                o_result.valid       = 1'b1;
                                o_result.item.status = lpcd_pkg::ST_DONE;
                            end else if (len_shift >
                                         {{(lpcd_pkg::LEN_W-lpcd_pkg::LIMIT_W){1'b0}},
                                          i_limit}) begin
                                n_phase              = lpcd_pkg::PH_IDLE;
                                o_result.valid       = 1'b1;
                                o_result.item.status = lpcd_pkg::ST_TOO_BIG;
                            end else begin
                                n_remaining = len_shift[lpcd_pkg::LIMIT_W-1:0];
                                n_phase     = lpcd_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                    lpcd_pkg::PH_PAYLOAD: begin
                        if (r_total != '1) begin
                            n_total = r_total + lpcd_pkg::TOTAL_W'(1);
                        end
                        if (last) begin
                            n_remaining = '0;
                            n_phase     = lpcd_pkg::PH_LENGTH;
                            n_idx       = '0;
                            n_len       = '0;
                        end else begin
                            n_remaining = r_remaining - lpcd_pkg::LIMIT_W'(1);
                        end
                        o_result.valid             = 1'b1;
                        o_result.item.status       = lpcd_pkg::ST_DATA;
                        o_result.item.payload_byte = i_item.rx_byte;
                        o_result.item.chunk_last   = last;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
        o_result.item.total_bytes = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lpcd_pkg::PH_IDLE;
            r_idx       <= '0;
            r_mismatch  <= 1'b0;
            r_len       <= '0;
            r_remaining <= '0;
            r_total     <= '0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_mismatch  <= n_mismatch;
            r_len       <= n_len;
            r_remaining <= n_remaining;
            r_total     <= n_total;
        end
    end

endmodule

// ===== rtl/length_prefixed_chunk_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_chunk_deframer
// Byte-stream deframer for length-prefixed download transfers.
//
// Input channel: one beat per received byte, close or start command.
// Output channel: one beat per payload byte or end-of-transfer status;
// status beats carry the saturating 48-bit payload byte count.
// A start command opens a transfer: the "OK" reply is checked, then
// four-byte big-endian lengths and their payload bytes follow.
// Length zero ends the transfer; all-ones, an over-limit length or a
// close while active ends it with an error status.
// An input beat passes the input register, the parse logic and the
// result register. Throughput: one beat per cycle while the receiver
// takes output, set by the combinational parse step between the two registers.
// A stalled receiver holds the result register; one further beat waits
// in the input register, then o_in_ready drops.
// Reset empties both registers, returns the parser to idle and sets the
// chunk limit register to 4096. Write the limit over APB at address 0
// while no transfer beat is in flight.
// ----------------------------------------------------------------------------
module length_prefixed_chunk_deframer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lpcd_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lpcd_pkg::t_out_item               o_out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpcd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lpcd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lpcd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic                         r_in_valid;
    lpcd_pkg::t_in_item           r_in_item;
    logic                         r_out_valid;
    lpcd_pkg::t_out_item          r_out_item;
    logic                         advance;
    logic [lpcd_pkg::LIMIT_W-1:0] limit;
    lpcd_pkg::t_result            result;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    lpcd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_limit (limit)
    );

    lpcd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_limit   (limit),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out_item <= result.item;
        end
    end

endmodule
